// ===== sv/owm_pkg.sv =====
`default_nettype none

package owm_pkg;

   // Widths of the item fields and of the internal counters.
   localparam int KindWidth  = 2;
   localparam int ByteWidth  = 8;
   localparam int LongWidth  = 10;
   localparam int ShortWidth = 8;
   localparam int PhaseWidth = 4;
   localparam int BitsWidth  = 4;
   localparam int AddrWidth  = 3;

   // Item kinds.
   localparam logic [KindWidth-1:0] KIND_TICK  = 2'd0;
   localparam logic [KindWidth-1:0] KIND_RESET = 2'd1;
   localparam logic [KindWidth-1:0] KIND_WRITE = 2'd2;
   localparam logic [KindWidth-1:0] KIND_READ  = 2'd3;

   // Register indexes.
   localparam logic [AddrWidth-1:0] REG_RESET_LOW     = 3'd0;
   localparam logic [AddrWidth-1:0] REG_PRESENCE_WAIT = 3'd1;
   localparam logic [AddrWidth-1:0] REG_RESET_TAIL    = 3'd2;
   localparam logic [AddrWidth-1:0] REG_SHORT_TIME    = 3'd3;
   localparam logic [AddrWidth-1:0] REG_LONG_TIME     = 3'd4;
   localparam logic [AddrWidth-1:0] REG_READ_LOW      = 3'd5;
   localparam logic [AddrWidth-1:0] REG_READ_SAMPLE   = 3'd6;

   // Register reset values.
   localparam logic [LongWidth-1:0]  RESET_LOW_DEFAULT     = 10'd600;
   localparam logic [LongWidth-1:0]  PRESENCE_WAIT_DEFAULT = 10'd60;
   localparam logic [LongWidth-1:0]  RESET_TAIL_DEFAULT    = 10'd600;
   localparam logic [ShortWidth-1:0] SHORT_TIME_DEFAULT    = 8'd5;
   localparam logic [ShortWidth-1:0] LONG_TIME_DEFAULT     = 8'd60;
   localparam logic [ShortWidth-1:0] READ_LOW_DEFAULT      = 8'd2;
   localparam logic [ShortWidth-1:0] READ_SAMPLE_DEFAULT   = 8'd8;

   // Bits in one byte transfer.
   localparam logic [BitsWidth-1:0] BYTE_BITS = 4'd8;

   // Sequencer phases.
   localparam logic [PhaseWidth-1:0] PH_IDLE     = 4'd0;
   localparam logic [PhaseWidth-1:0] PH_RST_LOW  = 4'd1;
   localparam logic [PhaseWidth-1:0] PH_RST_WAIT = 4'd2;
   localparam logic [PhaseWidth-1:0] PH_RST_TAIL = 4'd3;
   localparam logic [PhaseWidth-1:0] PH_WR_LOW   = 4'd4;
   localparam logic [PhaseWidth-1:0] PH_WR_REL   = 4'd5;
   localparam logic [PhaseWidth-1:0] PH_RD_LOW   = 4'd6;
   localparam logic [PhaseWidth-1:0] PH_RD_WAIT  = 4'd7;
   localparam logic [PhaseWidth-1:0] PH_RD_TAIL  = 4'd8;

   typedef struct packed {
      logic [LongWidth-1:0]  reset_low_us;
      logic [LongWidth-1:0]  presence_wait_us;
      logic [LongWidth-1:0]  reset_tail_us;
      logic [ShortWidth-1:0] short_time_us;
      logic [ShortWidth-1:0] long_time_us;
      logic [ShortWidth-1:0] read_low_us;
      logic [ShortWidth-1:0] read_sample_us;
   } cfg_type;

   typedef struct packed {
      logic [ByteWidth-1:0] read_data;
      logic                 presence;
      logic                 done_res;
      logic                 busy_res;
      logic                 drive_low;
   } result_type;

endpackage

`default_nettype wire

// ===== sv/owm_regs.sv =====
`default_nettype none

module owm_regs (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [owm_pkg::AddrWidth-1:0]       csr_addr,
   input  wire logic [owm_pkg::LongWidth-1:0]       csr_wdata,
   output owm_pkg::cfg_type                         cfg
);

   owm_pkg::cfg_type cfg_ff;
   owm_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            owm_pkg::REG_RESET_LOW:     cfg_in.reset_low_us     = csr_wdata;
            owm_pkg::REG_PRESENCE_WAIT: cfg_in.presence_wait_us = csr_wdata;
            owm_pkg::REG_RESET_TAIL:    cfg_in.reset_tail_us    = csr_wdata;
            owm_pkg::REG_SHORT_TIME:
               cfg_in.short_time_us = csr_wdata[owm_pkg::ShortWidth-1:0];
            owm_pkg::REG_LONG_TIME:
               cfg_in.long_time_us = csr_wdata[owm_pkg::ShortWidth-1:0];
            owm_pkg::REG_READ_LOW:
               cfg_in.read_low_us = csr_wdata[owm_pkg::ShortWidth-1:0];
            owm_pkg::REG_READ_SAMPLE:
               cfg_in.read_sample_us = csr_wdata[owm_pkg::ShortWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_us     <= owm_pkg::RESET_LOW_DEFAULT;
         cfg_ff.presence_wait_us <= owm_pkg::PRESENCE_WAIT_DEFAULT;
         cfg_ff.reset_tail_us    <= owm_pkg::RESET_TAIL_DEFAULT;
         cfg_ff.short_time_us    <= owm_pkg::SHORT_TIME_DEFAULT;
         cfg_ff.long_time_us     <= owm_pkg::LONG_TIME_DEFAULT;
         cfg_ff.read_low_us      <= owm_pkg::READ_LOW_DEFAULT;
         cfg_ff.read_sample_us   <= owm_pkg::READ_SAMPLE_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== sv/owm_engine.sv =====
`default_nettype none

module owm_engine (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                step_en,
   input  wire logic [owm_pkg::KindWidth-1:0]       kind,
   input  wire logic [owm_pkg::ByteWidth-1:0]       data_byte,
   input  wire logic                                line_in,
   input  owm_pkg::cfg_type                         cfg,
   output owm_pkg::result_type                      result
);

   logic [owm_pkg::PhaseWidth-1:0] phase_ff, phase_in;
   logic [owm_pkg::LongWidth-1:0]  time_ff, time_in;
   logic [owm_pkg::BitsWidth-1:0]  bits_ff, bits_in;
   logic [owm_pkg::ByteWidth-1:0]  shift_ff, shift_in;
   logic [owm_pkg::ByteWidth-1:0]  last_ff, last_in;
   logic                           pres_ff, pres_in;
   logic                           drive_ff, drive_in;
   logic                           done;
   logic [owm_pkg::LongWidth-1:0]  short_ext, long_ext, rd_low_ext, rd_sample_ext;

   assign short_ext     = {2'b00, cfg.short_time_us};
   assign long_ext      = {2'b00, cfg.long_time_us};
   assign rd_low_ext    = {2'b00, cfg.read_low_us};
   assign rd_sample_ext = {2'b00, cfg.read_sample_us};

   always_comb begin
      phase_in = phase_ff;
      time_in  = time_ff;
      bits_in  = bits_ff;
      shift_in = shift_ff;
      last_in  = last_ff;
      pres_in  = pres_ff;
      drive_in = drive_ff;
      done     = 1'b0;
      if (kind == owm_pkg::KIND_TICK) begin
         if (phase_ff != owm_pkg::PH_IDLE) begin
            if (time_ff > 10'd1) begin
               time_in = time_ff - 10'd1;
            end else begin
               // Count ran out: the next stage starts on this same tick.
               time_in = '0;
               case (phase_ff)
                  owm_pkg::PH_RST_LOW: begin
                     drive_in = 1'b0;
                     time_in  = cfg.presence_wait_us;
                     phase_in = owm_pkg::PH_RST_WAIT;
                  end
                  owm_pkg::PH_RST_WAIT: begin
                     // A device answers by holding the line low.
                     pres_in  = ~line_in;
                     time_in  = cfg.reset_tail_us;
                     phase_in = owm_pkg::PH_RST_TAIL;
                  end
                  owm_pkg::PH_RST_TAIL: begin
                     phase_in = owm_pkg::PH_IDLE;
                     done     = 1'b1;
                  end
                  owm_pkg::PH_WR_LOW: begin
                     drive_in = 1'b0;
                     time_in  = shift_ff[0] ? long_ext : short_ext;
                     phase_in = owm_pkg::PH_WR_REL;
                  end
                  owm_pkg::PH_WR_REL: begin
                     shift_in = {1'b0, shift_ff[owm_pkg::ByteWidth-1:1]};
                     bits_in  = bits_ff - 4'd1;
                     if (bits_in == '0) begin
                        phase_in = owm_pkg::PH_IDLE;
                        done     = 1'b1;
                     end else begin
                        // Next slot timed from the bit that just moved down.
                        drive_in = 1'b1;
                        time_in  = shift_ff[1] ? short_ext : long_ext;
                        phase_in = owm_pkg::PH_WR_LOW;
                     end
                  end
                  owm_pkg::PH_RD_LOW: begin
                     drive_in = 1'b0;
                     time_in  = rd_sample_ext;
                     phase_in = owm_pkg::PH_RD_WAIT;
                  end
                  owm_pkg::PH_RD_WAIT: begin
                     shift_in = {line_in, shift_ff[owm_pkg::ByteWidth-1:1]};
                     time_in  = long_ext;
                     phase_in = owm_pkg::PH_RD_TAIL;
                  end
                  owm_pkg::PH_RD_TAIL: begin
                     bits_in = bits_ff - 4'd1;
                     if (bits_in == '0) begin
                        last_in  = shift_ff;
                        phase_in = owm_pkg::PH_IDLE;
                        done     = 1'b1;
                     end else begin
                        drive_in = 1'b1;
                        time_in  = rd_low_ext;
                        phase_in = owm_pkg::PH_RD_LOW;
                     end
                  end
                  default: begin
                     phase_in = owm_pkg::PH_IDLE;
                     drive_in = 1'b0;
                  end
               endcase
            end
         end
      end else if (phase_ff == owm_pkg::PH_IDLE) begin
         drive_in = 1'b1;
         case (kind)
            owm_pkg::KIND_RESET: begin
               time_in  = cfg.reset_low_us;
               phase_in = owm_pkg::PH_RST_LOW;
            end
            owm_pkg::KIND_WRITE: begin
               shift_in = data_byte;
               bits_in  = owm_pkg::BYTE_BITS;
               time_in  = data_byte[0] ? short_ext : long_ext;
               phase_in = owm_pkg::PH_WR_LOW;
            end
            default: begin
               shift_in = '0;
               bits_in  = owm_pkg::BYTE_BITS;
               time_in  = rd_low_ext;
               phase_in = owm_pkg::PH_RD_LOW;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= owm_pkg::PH_IDLE;
         time_ff  <= '0;
         bits_ff  <= '0;
         shift_ff <= '0;
         last_ff  <= '0;
         pres_ff  <= 1'b0;
         drive_ff <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         time_ff  <= time_in;
         bits_ff  <= bits_in;
         shift_ff <= shift_in;
         last_ff  <= last_in;
         pres_ff  <= pres_in;
         drive_ff <= drive_in;
      end
   end

   assign result.drive_low = drive_in;
   assign result.busy_res  = (phase_in != owm_pkg::PH_IDLE);
   assign result.done_res  = done;
   assign result.presence  = pres_in;
   assign result.read_data = last_in;

endmodule

`default_nettype wire

// ===== sv/one_wire_bus_master.sv =====
`default_nettype none

// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  tdata: data_byte, line_in; tuser: kind
// rsp       out        rsp_tvalid/rsp_tready  tdata: drive_low .. read_data
// csr       in         csr_we                 csr_addr, csr_wdata (no read-back)
//
// Every accepted transfer yields exactly one result transfer. An item is held
// in the input register, then the bus sequencer steps once as the result is
// loaded into the output register, so a result passes through both registers
// and one item is taken per cycle when rsp_tready is high. Reset is
// synchronous and active high; it clears the sequencer, the valid flags and
// the timing registers to their defaults. A stall on rsp holds the output
// register and the input register, and req_tready drops only when both are
// full.
module one_wire_bus_master (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Request channel.
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   input  wire logic [15:0]                     req_tdata,  // [7:0] data_byte, [8] line_in
   input  wire logic [owm_pkg::KindWidth-1:0]   req_tuser,  // [1:0] kind
   // Result channel.
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   output      logic [15:0]                     rsp_tdata,  // [0] drive_low, [1] busy_res,
                                                            // [2] done_res, [3] presence,
                                                            // [11:4] read_data
   // Register write port.
   input  wire logic                            csr_we,
   input  wire logic [owm_pkg::AddrWidth-1:0]   csr_addr,
   input  wire logic [owm_pkg::LongWidth-1:0]   csr_wdata
);

   // Input register.
   logic                               in_valid_ff, in_valid_in;
   logic [owm_pkg::KindWidth-1:0]      in_kind_ff;
   logic [owm_pkg::ByteWidth-1:0]      in_byte_ff;
   logic                               in_line_ff;

   // Output register.
   logic                               out_valid_ff, out_valid_in;
   owm_pkg::result_type                out_ff;

   owm_pkg::cfg_type                   cfg;
   owm_pkg::result_type                result;
   logic                               advance;
   logic                               take;

   // The held item moves on whenever the output register is free or being
   // emptied in this cycle; that is also the one moment the sequencer steps.
   assign advance    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;
   assign take       = req_tvalid & req_tready;

   assign in_valid_in  = take | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_kind_ff <= req_tuser;
         in_byte_ff <= req_tdata[owm_pkg::ByteWidth-1:0];
         in_line_ff <= req_tdata[owm_pkg::ByteWidth];
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   owm_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   owm_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .kind      (in_kind_ff),
      .data_byte (in_byte_ff),
      .line_in   (in_line_ff),
      .cfg       (cfg),
      .result    (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_ff.read_data, out_ff.presence, out_ff.done_res,
                        out_ff.busy_res, out_ff.drive_low};

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   import owm_pkg::*;

   // The only register index past the end of the timing register list.
   localparam logic [AddrWidth-1:0] REG_UNUSED = 3'd7;

   // A stretch this long without any transfer on either channel means the block hung.
   localparam int STALL_LIMIT = 1000;

   // Results that can be typed in for the opening rows.
   localparam result_type IDLE_RESULT = '0;
   localparam result_type SLOT_LOW = '{read_data: 8'h00, presence: 1'b0, done_res: 1'b0,
                                       busy_res: 1'b1, drive_low: 1'b1};

   // One row of the opening table. When has_exp is low, the predictor supplies the result.
   typedef struct packed {
      logic [KindWidth-1:0] kind;
      logic [ByteWidth-1:0] data_in;
      logic                 line_in;
      logic                 has_exp;
      result_type           exp;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [15:0]            req_tdata = '0;
   logic [KindWidth-1:0]   req_tuser = KIND_TICK;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [15:0]            rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [AddrWidth-1:0]   csr_addr = '0;
   logic [LongWidth-1:0]   csr_wdata = '0;

   // Predicted state of the bus sequencer and its timing registers.
   cfg_type                timing;
   logic [PhaseWidth-1:0]  seq_state;
   logic [LongWidth-1:0]   us_left;
   logic [BitsWidth-1:0]   slots_left;
   logic [ByteWidth-1:0]   bit_shifter;
   logic                   device_found;
   logic                   pulling_low;
   logic [ByteWidth-1:0]   read_byte;

   // Bus results still owed by the block, oldest first.
   result_type             pending_bus_results[$];

   stim_row_type           opening_rows [16];
   int                     mismatch_count = 0;
   int                     burst_left = 0;
   int                     idle_cycles = 0;

   one_wire_bus_master u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] data_byte, [8] line_in
      .req_tuser  (req_tuser),   // [1:0] kind
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [0] drive_low, [1] busy_res, [2] done_res, [3] presence,
                                 // [11:4] read_data
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Puts the predictor into its power-up state with the default timing.
   function automatic void reset_bus_model();
      timing = '{reset_low_us: RESET_LOW_DEFAULT, presence_wait_us: PRESENCE_WAIT_DEFAULT,
                 reset_tail_us: RESET_TAIL_DEFAULT, short_time_us: SHORT_TIME_DEFAULT,
                 long_time_us: LONG_TIME_DEFAULT, read_low_us: READ_LOW_DEFAULT,
                 read_sample_us: READ_SAMPLE_DEFAULT};
      seq_state = PH_IDLE;
      us_left = '0;
      slots_left = '0;
      bit_shifter = '0;
      device_found = 1'b0;
      pulling_low = 1'b0;
      read_byte = '0;
   endfunction

   // A register write lands in the predictor exactly as the block stores it: the 8-bit
   // durations keep only the low byte, and the unused index changes nothing.
   function automatic void update_timing(input logic [AddrWidth-1:0] addr,
                                         input logic [LongWidth-1:0] value);
      case (addr)
         REG_RESET_LOW:     timing.reset_low_us = value;
         REG_PRESENCE_WAIT: timing.presence_wait_us = value;
         REG_RESET_TAIL:    timing.reset_tail_us = value;
         REG_SHORT_TIME:    timing.short_time_us = value[ShortWidth-1:0];
         REG_LONG_TIME:     timing.long_time_us = value[ShortWidth-1:0];
         REG_READ_LOW:      timing.read_low_us = value[ShortWidth-1:0];
         REG_READ_SAMPLE:   timing.read_sample_us = value[ShortWidth-1:0];
         default: ;
      endcase
   endfunction

   // Steps the predicted sequencer by one item and returns the bus result it should give.
   // A count that has run down to one or zero ends its stage on this tick, which is how a
   // duration of zero ends up lasting one microsecond.
   function automatic result_type predict_bus_result(input logic [KindWidth-1:0] kind,
                                                     input logic [ByteWidth-1:0] data_in,
                                                     input logic line);
      result_type r;
      logic       finished;
      finished = 1'b0;
      if (kind == KIND_TICK) begin
         if (seq_state == PH_IDLE) begin
            // An idle bus just lets time pass.
         end else if (us_left > 1) begin
            us_left = us_left - 1'b1;
         end else begin
            us_left = '0;
            case (seq_state)
               PH_RST_LOW: begin
                  pulling_low = 1'b0;
                  us_left = timing.presence_wait_us;
                  seq_state = PH_RST_WAIT;
               end
               PH_RST_WAIT: begin
                  // A device answers by holding the line low.
                  device_found = ~line;
                  us_left = timing.reset_tail_us;
                  seq_state = PH_RST_TAIL;
               end
               PH_RST_TAIL: begin
                  seq_state = PH_IDLE;
                  finished = 1'b1;
               end
               PH_WR_LOW: begin
                  pulling_low = 1'b0;
                  us_left = bit_shifter[0] ? LongWidth'(timing.long_time_us)
                                           : LongWidth'(timing.short_time_us);
                  seq_state = PH_WR_REL;
               end
               PH_WR_REL: begin
                  bit_shifter = bit_shifter >> 1;
                  slots_left = slots_left - 1'b1;
                  if (slots_left == 0) begin
                     seq_state = PH_IDLE;
                     finished = 1'b1;
                  end else begin
                     pulling_low = 1'b1;
                     us_left = bit_shifter[0] ? LongWidth'(timing.short_time_us)
                                              : LongWidth'(timing.long_time_us);
                     seq_state = PH_WR_LOW;
                  end
               end
               PH_RD_LOW: begin
                  pulling_low = 1'b0;
                  us_left = LongWidth'(timing.read_sample_us);
                  seq_state = PH_RD_WAIT;
               end
               PH_RD_WAIT: begin
                  bit_shifter = {line, bit_shifter[ByteWidth-1:1]};
                  us_left = LongWidth'(timing.long_time_us);
                  seq_state = PH_RD_TAIL;
               end
               PH_RD_TAIL: begin
                  slots_left = slots_left - 1'b1;
                  if (slots_left == 0) begin
                     read_byte = bit_shifter;
                     seq_state = PH_IDLE;
                     finished = 1'b1;
                  end else begin
                     pulling_low = 1'b1;
                     us_left = LongWidth'(timing.read_low_us);
                     seq_state = PH_RD_LOW;
                  end
               end
               default: begin
                  seq_state = PH_IDLE;
                  pulling_low = 1'b0;
               end
            endcase
         end
      end else if (seq_state == PH_IDLE) begin
         // Commands start only on an idle bus; while busy they are dropped.
         pulling_low = 1'b1;
         case (kind)
            KIND_RESET: begin
               us_left = timing.reset_low_us;
               seq_state = PH_RST_LOW;
            end
            KIND_WRITE: begin
               bit_shifter = data_in;
               slots_left = BYTE_BITS;
               us_left = data_in[0] ? LongWidth'(timing.short_time_us)
                                    : LongWidth'(timing.long_time_us);
               seq_state = PH_WR_LOW;
            end
            default: begin
               bit_shifter = '0;
               slots_left = BYTE_BITS;
               us_left = LongWidth'(timing.read_low_us);
               seq_state = PH_RD_LOW;
            end
         endcase
      end
      r.drive_low = pulling_low;
      r.busy_res = (seq_state != PH_IDLE);
      r.done_res = finished;
      r.presence = device_found;
      r.read_data = read_byte;
      return r;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Offers one item in bursts with random gaps. On acceptance the predictor steps and the
   // expected result is queued; a typed-in result takes its place where one is given.
   task automatic send_item(input logic [KindWidth-1:0] kind,
                            input logic [ByteWidth-1:0] data_in,
                            input logic line_in,
                            input logic has_exp,
                            input result_type typed);
      int         gap;
      result_type predicted;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {7'b0, line_in, data_in};
      do @(posedge clock); while (req_tready !== 1'b1);
      predicted = predict_bus_result(kind, data_in, line_in);
      pending_bus_results.push_back(has_exp ? typed : predicted);
   endtask

   // Stops offering items, then waits until every owed result has been taken.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_bus_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes all seven timing registers and the unused index, one write per cycle.
   task automatic load_timing(input logic [LongWidth-1:0] rst_low,
                              input logic [LongWidth-1:0] pres_wait,
                              input logic [LongWidth-1:0] rst_tail,
                              input logic [LongWidth-1:0] short_us,
                              input logic [LongWidth-1:0] long_us,
                              input logic [LongWidth-1:0] rd_low,
                              input logic [LongWidth-1:0] rd_sample);
      logic [LongWidth-1:0] values [8];
      logic [AddrWidth-1:0] idx;
      values = '{rst_low, pres_wait, rst_tail, short_us, long_us, rd_low, rd_sample,
                 LongWidth'($urandom)};
      for (int i = 0; i < 8; i++) begin
         idx = AddrWidth'(i);
         csr_we <= 1'b1;
         csr_addr <= idx;
         csr_wdata <= values[i];
         @(posedge clock);
         update_timing(idx, values[i]);
      end
      csr_we <= 1'b0;
   endtask

   // Random traffic, mostly well-formed: a command on an idle bus and then ticks until it
   // completes. Commands on a busy bus and ticks on an idle one are sprinkled in as noise,
   // and only the items that do something count toward the total.
   task automatic run_traffic(input int items_wanted);
      int                   counted;
      logic [KindWidth-1:0] kind;
      logic                 bus_busy;
      counted = 0;
      while (counted < items_wanted) begin
         bus_busy = (seq_state != PH_IDLE);
         if (bus_busy)
            kind = ($urandom_range(0, 19) == 0) ? KindWidth'($urandom_range(1, 3)) : KIND_TICK;
         else
            kind = ($urandom_range(0, 4) == 0) ? KIND_TICK : KindWidth'($urandom_range(1, 3));
         if (bus_busy == (kind == KIND_TICK))
            counted++;
         send_item(kind, 8'($urandom), 1'($urandom_range(0, 1)), 1'b0, IDLE_RESULT);
      end
   endtask

   // Every accepted result transfer is checked field by field against the oldest
   // expectation, including the zero padding above read_data.
   always @(posedge clock) begin : rsp_check
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata[11:0]);
         if (pending_bus_results.size() == 0) begin
            $display("%0t: unexpected result transfer, expected none, got %h", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_bus_results.pop_front();
            check_field("drive_low", want.drive_low, got.drive_low);
            check_field("busy_res", want.busy_res, got.busy_res);
            check_field("done_res", want.done_res, got.done_res);
            check_field("presence", want.presence, got.presence);
            check_field("read_data", want.read_data, got.read_data);
            check_field("padding", 0, rsp_tdata[15:12]);
         end
      end
   end

   // The receiver stalls in windows of random length and density. The tenth window, and
   // now and then another, holds rsp_tready low for a long stretch so that both internal
   // registers fill and req_tready drops while items are still being offered.
   initial begin : rsp_stall
      int windows;
      int ready_pct;
      windows = 0;
      while (reset) @(posedge clock);
      forever begin
         windows++;
         if (windows == 10 || $urandom_range(0, 24) == 0) begin
            rsp_tready <= 1'b0;
            repeat (64) @(posedge clock);
         end else begin
            case ($urandom_range(0, 2))
               0:       ready_pct = 100;
               1:       ready_pct = 60;
               default: ready_pct = 25;
            endcase
            repeat ($urandom_range(16, 80)) begin
               rsp_tready <= ($urandom_range(1, 100) <= ready_pct);
               @(posedge clock);
            end
         end
      end
   end

   // A run that stops moving is a failure; the limit sits well above the long stall.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      // The opening table runs on the reset timing. Idle ticks must change nothing, a read
      // must pull the line at once, and commands given while busy must be dropped. The
      // remaining ticks release the line after the default read pulse and take the first
      // read sample, and are left to the predictor.
      opening_rows = '{
         '{KIND_TICK,  8'h00, 1'b0, 1'b1, IDLE_RESULT},
         '{KIND_TICK,  8'hFF, 1'b1, 1'b1, IDLE_RESULT},
         '{KIND_READ,  8'h00, 1'b0, 1'b1, SLOT_LOW},
         '{KIND_WRITE, 8'hFF, 1'b1, 1'b1, SLOT_LOW},
         '{KIND_RESET, 8'h00, 1'b0, 1'b1, SLOT_LOW},
         '{KIND_READ,  8'h5A, 1'b1, 1'b1, SLOT_LOW},
         '{KIND_TICK,  8'h00, 1'b1, 1'b0, IDLE_RESULT},
         '{KIND_TICK,  8'hFF, 1'b0, 1'b0, IDLE_RESULT},
         '{KIND_TICK,  8'h00, 1'b1, 1'b0, IDLE_RESULT},
         '{KIND_TICK,  8'hFF, 1'b0, 1'b0, IDLE_RESULT},
         '{KIND_TICK,  8'h00, 1'b1, 1'b0, IDLE_RESULT},
         '{KIND_TICK,  8'hFF, 1'b0, 1'b0, IDLE_RESULT},
         '{KIND_TICK,  8'h00, 1'b1, 1'b0, IDLE_RESULT},
         '{KIND_TICK,  8'hFF, 1'b0, 1'b0, IDLE_RESULT},
         '{KIND_TICK,  8'h00, 1'b1, 1'b0, IDLE_RESULT},
         '{KIND_TICK,  8'hFF, 1'b1, 1'b0, IDLE_RESULT}
      };
      reset_bus_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_rows[i])
         send_item(opening_rows[i].kind, opening_rows[i].data_in, opening_rows[i].line_in,
                   opening_rows[i].has_exp, opening_rows[i].exp);

      // Random traffic on the reset timing; the slow default read is still in flight
      // when the registers change below, so new durations take effect mid-operation.
      run_traffic(100);

      // Zero durations must behave like one microsecond.
      wait_drained();
      load_timing(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
      run_traffic(180);

      // The smallest legal durations.
      wait_drained();
      load_timing(10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1);
      run_traffic(180);

      // Short random timings keep many whole operations inside the item budget.
      for (int p = 0; p < 3; p++) begin
         wait_drained();
         load_timing(LongWidth'($urandom_range(0, 6)), LongWidth'($urandom_range(0, 6)),
                     LongWidth'($urandom_range(0, 6)), LongWidth'($urandom_range(0, 6)),
                     LongWidth'($urandom_range(0, 12)), LongWidth'($urandom_range(0, 6)),
                     LongWidth'($urandom_range(0, 6)));
         run_traffic(160);
      end

      // The largest durations, with all-ones written to the 8-bit short time so that only
      // its low byte is kept. A command started here loads a full count and runs it down
      // for the rest of this stretch without reaching its end.
      wait_drained();
      load_timing(10'd1023, 10'd1023, 10'd1023, 10'h3FF, 10'd255, 10'd255, 10'd255);
      run_traffic(40);

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
